### rtl/core/nlog_pkg.sv
// Shared types, widths and constants for the fixed-point natural log unit.
// Used by nlog_mul, nlog_div and natural_log_fixed_point_unit; no dependencies.
package nlog_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_TERMS_DEF = 19;

	localparam int VAL_W  = 32;
	localparam int RES_W  = 21;
	localparam int STAT_W = 2;
	localparam int LIM_W  = 5;
	localparam int MAN_W  = 30;
	localparam int MUL_W  = 31;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 40;

	localparam logic [LIM_W-1:0] TERM_LIMIT_RST = 5'd19;

	localparam logic signed [ACC_W-1:0] LN2_Q30 = 40'sd744261118;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NAN     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NEG_INF = 2'd2;

	// floor(2^32 / (2n+1)) for series step n
	function automatic logic [MUL_W-1:0] rcp_of(input logic [LIM_W-1:0] n);
		logic [MUL_W-1:0] r;
		case (n)
			5'd1:    r = 31'd1431655765;
			5'd2:    r = 31'd858993459;
			5'd3:    r = 31'd613566756;
			5'd4:    r = 31'd477218588;
			5'd5:    r = 31'd390451572;
			5'd6:    r = 31'd330382099;
			5'd7:    r = 31'd286331153;
			5'd8:    r = 31'd252645135;
			5'd9:    r = 31'd226050910;
			5'd10:   r = 31'd204522252;
			5'd11:   r = 31'd186737708;
			5'd12:   r = 31'd171798691;
			5'd13:   r = 31'd159072862;
			5'd14:   r = 31'd148102320;
			5'd15:   r = 31'd138547332;
			5'd16:   r = 31'd130150524;
			5'd17:   r = 31'd122713351;
			5'd18:   r = 31'd116080197;
			5'd19:   r = 31'd110127366;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/nlog_mul.sv
// Shared unsigned 31x31 multiplier with registered product.
// Depends on nlog_pkg.
module nlog_mul import nlog_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

### rtl/core/nlog_div.sv
// Radix-4 restoring divider: {num_hi, num_lo} / den, 30 quotient bits.
// Depends on nlog_pkg.
module nlog_div import nlog_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAN_W-1:0] num_hi,
	input  logic [MAN_W-1:0] num_lo,
	input  logic [MUL_W-1:0] den,
	output logic             done,
	output logic [MAN_W-1:0] quo
);

	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] LAST_STEP = 4'd14;

	logic [MUL_W-1:0] rem_q;
	logic [MUL_W-1:0] den_q;
	logic [MAN_W-1:0] lo_q;
	logic [MAN_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MUL_W:0]   s1, s2;
	logic [MUL_W-1:0] r1, r2;
	logic             qb1, qb2;

	always_comb begin
		s1  = {rem_q, lo_q[MAN_W-1]};
		qb1 = (s1 >= {1'b0, den_q});
		r1  = qb1 ? MUL_W'(s1 - {1'b0, den_q}) : MUL_W'(s1);
		s2  = {r1, lo_q[MAN_W-2]};
		qb2 = (s2 >= {1'b0, den_q});
		r2  = qb2 ? MUL_W'(s2 - {1'b0, den_q}) : MUL_W'(s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num_hi};
			lo_q  <= num_lo;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2;
			lo_q  <= {lo_q[MAN_W-3:0], 2'b00};
			quo_q <= {quo_q[MAN_W-3:0], qb1, qb2};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/natural_log_fixed_point_unit.sv
// Fixed-point natural log unit, top level over nlog_mul, nlog_div and nlog_pkg.
// Negative, zero or one inputs go straight to ST_FIN; others normalize, divide, then
// run the series, each term through ST_TMUL, ST_TRND, ST_TDIV and ST_TCOR.
// One item at a time; in_ready is high only when idle, so the next item can be
// accepted in the cycle after the result is posted, later while an earlier result
// waits on out_ready. arst_n clears control, term_limit -> 19.
module natural_log_fixed_point_unit import nlog_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [LIM_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [RES_W-1:0]  log_result,
	output logic [STAT_W-1:0]        status
);

	localparam int SH = 30 - FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'((64'd1 << SH) >> 1);
	localparam logic [VAL_W-1:0] ONE_IN = VAL_W'(64'd1 << FRAC_BITS);
	localparam logic signed [6:0] FRAC_S = 7'(FRAC_BITS);
	localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_TERMS);
	localparam logic signed [ACC_W-1:0] OUT_MAX = 40'sd1048575;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -40'sd1048576;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_NORM = 11'b00000000010,
		ST_PREP = 11'b00000000100,
		ST_DIV  = 11'b00000001000,
		ST_SQR  = 11'b00000010000,
		ST_SQW  = 11'b00000100000,
		ST_TMUL = 11'b00001000000,
		ST_TRND = 11'b00010000000,
		ST_TDIV = 11'b00100000000,
		ST_TCOR = 11'b01000000000,
		ST_FIN  = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [LIM_W-1:0]         term_limit_q;
	logic [30:0]              x_q;
	logic [4:0]               p_q;
	logic [MAN_W-1:0]         zmag_q, z2_q, term_q;
	logic [MUL_W-1:0]         sum_q;
	logic [LIM_W-1:0]         n_q;
	logic signed [ACC_W-1:0]  klog_q;
	logic [STAT_W-1:0]        stat_q;
	logic                     out_valid_q;
	logic signed [RES_W-1:0]  log_result_q;
	logic [STAT_W-1:0]        status_q;

	logic [LIM_W-1:0]         lim;
	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        prod_rnd;
	logic [MAN_W-1:0]         rnd30;
	logic                     div_start, div_done;
	logic [MAN_W-1:0]         div_quo;
	logic [MAN_W-1:0]         mant;
	logic [MUL_W-1:0]         amag_w, den_w;
	logic signed [6:0]        k_s;
	logic [MUL_W-1:0]         y;
	logic [7:0]               d8;
	logic [MAN_W-1:0]         q0;
	logic [15:0]              qd;
	logic [7:0]               r8;
	logic [MAN_W-1:0]         add;
	logic signed [ACC_W-1:0]  r_full, r_sh;
	logic signed [RES_W-1:0]  res_sat;
	logic                     in_acc;

	assign lim    = (term_limit_q > MAX_LIM) ? MAX_LIM : term_limit_q;
	assign in_acc = in_valid && in_ready;

	always_comb begin
		mant   = x_q[30:1];
		amag_w = (MUL_W'(1) << 30) - {1'b0, mant};
		den_w  = {1'b1, mant};
		k_s    = $signed({2'b00, p_q}) + 7'sd1 - FRAC_S;

		prod_rnd = prod + (PROD_W'(1) << 29);
		rnd30    = prod_rnd[59:30];

		y   = {1'b0, term_q} + MUL_W'(n_q);
		d8  = {2'b00, n_q, 1'b1};
		q0  = prod[61:32];
		qd  = 16'(q0[7:0]) * 16'(d8);
		r8  = y[7:0] - qd[7:0];
		add = q0 + MAN_W'(r8 >= d8);

		r_full = klog_q - ($signed(ACC_W'(sum_q)) <<< 1);
		r_sh   = (r_full + HALF) >>> SH;
		if (r_sh > OUT_MAX) begin
			res_sat = RES_W'(OUT_MAX);
		end else if (r_sh < OUT_MIN) begin
			res_sat = RES_W'(OUT_MIN);
		end else begin
			res_sat = RES_W'(r_sh);
		end
	end

	always_comb begin
		case (state_q)
			ST_SQR: begin
				mul_a = {1'b0, zmag_q};
				mul_b = {1'b0, zmag_q};
			end
			ST_TMUL: begin
				mul_a = {1'b0, term_q};
				mul_b = {1'b0, z2_q};
			end
			ST_TDIV: begin
				mul_a = y;
				mul_b = rcp_of(n_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_PREP);

	nlog_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	nlog_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (amag_w[MAN_W-1:0]),
		.num_lo (den_w[MUL_W-1:1]),
		.den    (den_w),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_limit_q <= TERM_LIMIT_RST;
		end else if (cfg_we) begin
			term_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (value[VAL_W-1] || value == '0 || value == ONE_IN) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (x_q[30]) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_SQW;
				ST_SQW: state_q <= (lim == '0) ? ST_FIN : ST_TMUL;
				ST_TMUL: state_q <= ST_TRND;
				ST_TRND: state_q <= ST_TDIV;
				ST_TDIV: state_q <= ST_TCOR;
				ST_TCOR: begin
					if (add == '0 || n_q == lim) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_TMUL;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q    <= value[30:0];
					p_q    <= 5'd30;
					klog_q <= '0;
					sum_q  <= '0;
					if (value[VAL_W-1]) begin
						stat_q <= STAT_NAN;
					end else if (value == '0) begin
						stat_q <= STAT_NEG_INF;
					end else begin
						stat_q <= STAT_OK;
					end
				end
			end
			ST_NORM: begin
				if (!x_q[30]) begin
					if (x_q[30:23] == '0) begin
						x_q <= {x_q[22:0], 8'h00};
						p_q <= p_q - 5'd8;
					end else begin
						x_q <= {x_q[29:0], 1'b0};
						p_q <= p_q - 5'd1;
					end
				end
			end
			ST_PREP: klog_q <= LN2_Q30 * ACC_W'(k_s);
			ST_DIV: begin
				if (div_done) begin
					zmag_q <= div_quo;
					term_q <= div_quo;
					sum_q  <= {1'b0, div_quo};
				end
			end
			ST_SQW: begin
				z2_q <= rnd30;
				n_q  <= 5'd1;
			end
			ST_TRND: term_q <= rnd30;
			ST_TCOR: begin
				if (add != '0) begin
					sum_q <= sum_q + {1'b0, add};
					n_q   <= n_q + 5'd1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					log_result_q <= res_sat;
					status_q     <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign log_result = log_result_q;
	assign status     = status_q;

endmodule
